// ===== src/bipartite_max_matching_defines.svh =====
// Assertion macros shared by the matching block
`ifndef BIPARTITE_MAX_MATCHING_DEFINES_SVH
`define BIPARTITE_MAX_MATCHING_DEFINES_SVH

// same-cycle implication
`define BMM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bmm_pkg.sv =====
package bmm_pkg;

   // vertex limit default
   localparam int MAX_VERTICES_DEF = 64;

   // fixed field widths
   localparam int CMD_W = 2;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

   // register indexes
   localparam logic CSR_LEFT  = 1'b0;
   localparam logic CSR_RIGHT = 1'b1;

   // adjacency store operation
   typedef struct packed {
      logic clear;
      logic write;
   } adj_op_type;

endpackage

// ===== src/bmm_if.sv =====
// request word channel
interface bmm_req_if;
   logic                      valid;
   logic                      ready;
   logic [bmm_pkg::CMD_W-1:0] command;
   logic [bmm_pkg::IDX_W-1:0] left_index;
   logic [bmm_pkg::IDX_W-1:0] right_index;

   modport source (output valid, command, left_index, right_index, input ready);
   modport sink   (input valid, command, left_index, right_index, output ready);
endinterface

// result word channel
interface bmm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bmm_pkg::CNT_W-1:0] match_count;
   logic                      all_matched;

   modport source (output valid, match_count, all_matched, input ready);
   modport sink   (input valid, match_count, all_matched, output ready);
endinterface

// ===== src/bmm_adj_store.sv =====
module bmm_adj_store #(
   parameter int MAX_VERTICES = bmm_pkg::MAX_VERTICES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bmm_pkg::adj_op_type               op,
   input  logic [$clog2(MAX_VERTICES)-1:0]   raddr,
   input  logic [$clog2(MAX_VERTICES)-1:0]   waddr,
   input  logic [$clog2(MAX_VERTICES)-1:0]   wbit,
   output logic [MAX_VERTICES-1:0]           row_q
);
   import bmm_pkg::*;

   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] q_ff;
   logic                    qv_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] row_valid_in;
   logic [MAX_VERTICES-1:0] bit_mask;

   // a row never written since the last clear reads as empty
   assign row_q    = qv_ff ? q_ff : '0;
   assign bit_mask = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << wbit;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (op.clear) begin
         row_valid_in = '0;
      end else if (op.write) begin
         row_valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         qv_ff        <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         qv_ff        <= row_valid_ff[raddr];
      end
   end

   // row memory: read every cycle, write merges the bit into the row read before
   always_ff @(posedge clock) begin
      q_ff <= mem[raddr];
      if (op.write) begin
         mem[waddr] <= row_q | bit_mask;
      end
   end

endmodule

// ===== src/bmm_ctrl.sv =====
`include "bipartite_max_matching_defines.svh"

module bmm_ctrl #(
   parameter int MAX_VERTICES = bmm_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bmm_pkg::CMD_W-1:0]           cmd,
   input  logic [bmm_pkg::IDX_W-1:0]           li,
   input  logic [bmm_pkg::IDX_W-1:0]           ri,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]   lc_eff,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]   rc_eff,
   output logic                                ready,
   output bmm_pkg::adj_op_type                 adj_op,
   output logic [$clog2(MAX_VERTICES)-1:0]     adj_raddr,
   output logic [$clog2(MAX_VERTICES)-1:0]     adj_waddr,
   output logic [$clog2(MAX_VERTICES)-1:0]     adj_wbit,
   input  logic [MAX_VERTICES-1:0]             adj_row,
   input  logic                                res_free,
   output logic                                res_valid,
   output logic [$clog2(MAX_VERTICES+1)-1:0]   res_count,
   output logic                                res_all
);
   import bmm_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES+1);
   localparam int DW = $clog2(MAX_VERTICES+2);
   localparam int FW = 2*VW + CW;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EDGE = 8'b0000_0010,
      S_ROOT = 8'b0000_0100,
      S_SCAN = 8'b0000_1000,
      S_PART = 8'b0001_0000,
      S_POP  = 8'b0010_0000,
      S_FIX  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     u_ff, u_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [VW-1:0]     cur_left_ff, cur_left_in;
   logic [CW-1:0]     cur_next_ff, cur_next_in;
   logic [VW-1:0]     chosen_ff, chosen_in;
   logic [DW-1:0]     depth_ff, depth_in;
   logic [VW-1:0]     k_ff, k_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] pvalid_ff, pvalid_in;
   logic [VW-1:0]     edge_li_ff, edge_li_in;
   logic [VW-1:0]     edge_ri_ff, edge_ri_in;

   // partner and stack memories
   logic [VW-1:0]     part_mem [MAX_VERTICES];
   logic [VW-1:0]     part_q_ff;
   logic              part_we;
   logic [VW-1:0]     part_waddr;
   logic [VW-1:0]     part_wdata;
   logic [FW-1:0]     st_mem [MAX_VERTICES];
   logic [FW-1:0]     st_q_ff;
   logic              st_we;
   logic [VW-1:0]     st_waddr;
   logic [VW-1:0]     st_raddr;
   logic [FW-1:0]     st_wdata;

   logic [VW-1:0]     v_idx;
   logic              scan_live;
   logic [VW-1:0]     st_left;
   logic [CW-1:0]     st_next;
   logic [VW-1:0]     st_chosen;
   logic              edge_ok;

   assign v_idx     = cur_next_ff[VW-1:0];
   assign scan_live = cur_next_ff < rc_eff;
   assign {st_left, st_next, st_chosen} = st_q_ff;
   assign edge_ok   = (32'(li) < 32'(lc_eff)) && (32'(ri) < 32'(rc_eff));

   assign ready     = (state_ff == S_IDLE);
   assign res_count = count_ff;
   assign res_all   = (count_ff == lc_eff);
   assign adj_waddr = edge_li_ff;
   assign adj_wbit  = edge_ri_ff;

   // sequencer: one right vertex tested per scan cycle
   always_comb begin
      state_in    = state_ff;
      u_in        = u_ff;
      count_in    = count_ff;
      cur_left_in = cur_left_ff;
      cur_next_in = cur_next_ff;
      chosen_in   = chosen_ff;
      depth_in    = depth_ff;
      k_in        = k_ff;
      visited_in  = visited_ff;
      pvalid_in   = pvalid_ff;
      edge_li_in  = edge_li_ff;
      edge_ri_in  = edge_ri_ff;
      adj_op      = '0;
      part_we     = 1'b0;
      part_waddr  = chosen_ff;
      part_wdata  = cur_left_ff;
      st_we       = 1'b0;
      st_waddr    = VW'(depth_ff - DW'(1));
      st_wdata    = {cur_left_ff, cur_next_ff, chosen_ff};
      st_raddr    = VW'(depth_ff - DW'(2));
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_CLEAR: begin
                     adj_op.clear = 1'b1;
                  end
                  CMD_EDGE: begin
                     edge_li_in = VW'(li);
                     edge_ri_in = VW'(ri);
                     if (edge_ok) begin
                        state_in = S_EDGE;
                     end
                  end
                  CMD_RUN: begin
                     pvalid_in = '0;
                     u_in      = '0;
                     count_in  = '0;
                     state_in  = S_ROOT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EDGE: begin
            adj_op.write = 1'b1;
            state_in     = S_IDLE;
         end
         S_ROOT: begin
            if (u_ff >= lc_eff) begin
               state_in = S_DONE;
            end else begin
               visited_in  = '0;
               depth_in    = DW'(1);
               cur_left_in = VW'(u_ff);
               cur_next_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_live) begin
               cur_next_in = cur_next_ff + CW'(1);
               if (adj_row[v_idx] && !visited_ff[v_idx]) begin
                  visited_in[v_idx] = 1'b1;
                  chosen_in         = v_idx;
                  state_in          = S_PART;
               end
            end else if (depth_ff == DW'(1)) begin
               // root exhausted without a path
               u_in     = u_ff + CW'(1);
               state_in = S_ROOT;
            end else begin
               depth_in = depth_ff - DW'(1);
               state_in = S_POP;
            end
         end
         S_PART: begin
            if (!pvalid_ff[chosen_ff]) begin
               // free right vertex: flip the path, top frame first
               part_we            = 1'b1;
               pvalid_in[chosen_ff] = 1'b1;
               if (depth_ff == DW'(1)) begin
                  count_in = count_ff + CW'(1);
                  u_in     = u_ff + CW'(1);
                  state_in = S_ROOT;
               end else begin
                  k_in     = VW'(depth_ff - DW'(2));
                  state_in = S_FIX;
               end
            end else begin
               // descend into the current partner
               st_we       = 1'b1;
               depth_in    = depth_ff + DW'(1);
               cur_left_in = part_q_ff;
               cur_next_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_POP: begin
            cur_left_in = st_left;
            cur_next_in = st_next;
            chosen_in   = st_chosen;
            state_in    = S_SCAN;
         end
         S_FIX: begin
            part_we              = 1'b1;
            part_waddr           = st_chosen;
            part_wdata           = st_left;
            pvalid_in[st_chosen] = 1'b1;
            st_raddr             = k_ff - VW'(1);
            if (k_ff == '0) begin
               count_in = count_ff + CW'(1);
               u_in     = u_ff + CW'(1);
               state_in = S_ROOT;
            end else begin
               k_in = k_ff - VW'(1);
            end
         end
         S_DONE: begin
            if (res_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // adjacency row: the request's left index in idle, else the next top-of-stack vertex
      adj_raddr = (state_ff == S_IDLE) ? VW'(li) : cur_left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         u_ff       <= '0;
         count_ff   <= '0;
         depth_ff   <= '0;
         visited_ff <= '0;
         pvalid_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         u_ff       <= u_in;
         count_ff   <= count_in;
         depth_ff   <= depth_in;
         visited_ff <= visited_in;
         pvalid_ff  <= pvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_left_ff <= cur_left_in;
      cur_next_ff <= cur_next_in;
      chosen_ff   <= chosen_in;
      k_ff        <= k_in;
      edge_li_ff  <= edge_li_in;
      edge_ri_ff  <= edge_ri_in;
   end

   // partner memory, read at the vertex under test
   always_ff @(posedge clock) begin
      part_q_ff <= part_mem[v_idx];
      if (part_we) begin
         part_mem[part_waddr] <= part_wdata;
      end
   end

   // frame stack below the top frame
   always_ff @(posedge clock) begin
      st_q_ff <= st_mem[st_raddr];
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
   end

   `BMM_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == S_SCAN, cur_next_ff <= rc_eff, "scan beyond right count")
   `BMM_ASSERT_IMPL(a_count_le_root, clock, reset, 1'b1, count_ff <= u_ff, "more matches than roots")
   `BMM_ASSERT_IMPL(a_fix_below_top, clock, reset, state_ff == S_FIX, 32'(k_ff) < 32'(depth_ff), "fix walk above stack")
   `BMM_ASSERT_NEXT(a_run_start, clock, reset, start && (cmd == CMD_RUN), state_ff == S_ROOT, "run did not start")

endmodule

// ===== src/bipartite_max_matching.sv =====
// Add edge reads the row, then writes it back with the bit merged; an out-of-range edge
// is dropped. A run word tries each left root, scanning right vertices and pushing,
// popping and rematching frames, all in the single scan/compare sequencer. Ready is
// low while an edge or run word is in progress, one word at a time; the result waits
// in an output register, and a full register holds the run in its final state.
// Reset is synchronous: counts go to 0, adjacency rows read empty, no clearing pass.
module bipartite_max_matching #(
   parameter int MAX_VERTICES = bmm_pkg::MAX_VERTICES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   bmm_req_if.sink                    req,
   bmm_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [bmm_pkg::CNT_W-1:0]  csr_wdata
);
   import bmm_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES+1);

   logic [CNT_W-1:0] left_count_ff, left_count_in;
   logic [CNT_W-1:0] right_count_ff, right_count_in;
   logic [CW-1:0]    lc_eff;
   logic [CW-1:0]    rc_eff;
   logic             start;
   logic             ctrl_ready;
   adj_op_type       adj_op;
   logic [VW-1:0]    adj_raddr;
   logic [VW-1:0]    adj_waddr;
   logic [VW-1:0]    adj_wbit;
   logic [MAX_VERTICES-1:0] adj_row;
   logic             res_valid;
   logic [CW-1:0]    res_count;
   logic             res_all;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] match_count_ff;
   logic             all_matched_ff;

   // register writes
   always_comb begin
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEFT:  left_count_in  = csr_wdata;
            CSR_RIGHT: right_count_in = csr_wdata;
            default:   left_count_in  = left_count_ff;
         endcase
      end
   end

   // counts saturate at the vertex limit
   assign lc_eff = (32'(left_count_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(left_count_ff);
   assign rc_eff = (32'(right_count_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(right_count_ff);

   assign req.ready = ctrl_ready;
   assign start     = req.valid && ctrl_ready;

   bmm_adj_store #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
      .clock (clock),
      .reset (reset),
      .op    (adj_op),
      .raddr (adj_raddr),
      .waddr (adj_waddr),
      .wbit  (adj_wbit),
      .row_q (adj_row)
   );

   bmm_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (req.command),
      .li        (req.left_index),
      .ri        (req.right_index),
      .lc_eff    (lc_eff),
      .rc_eff    (rc_eff),
      .ready     (ctrl_ready),
      .adj_op    (adj_op),
      .adj_raddr (adj_raddr),
      .adj_waddr (adj_waddr),
      .adj_wbit  (adj_wbit),
      .adj_row   (adj_row),
      .res_free  (!rsp_valid_ff),
      .res_valid (res_valid),
      .res_count (res_count),
      .res_all   (res_all)
   );

   // result output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff  <= '0;
         right_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         match_count_ff <= CNT_W'(res_count);
         all_matched_ff <= res_all;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.match_count = match_count_ff;
   assign rsp.all_matched = all_matched_ff;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bmm_pkg::*;

   localparam int VMAX      = MAX_VERTICES_DEF;
   localparam int ITEMS     = 2000;
   localparam int CYCLE_CAP = 40000000;

   // command code with no meaning to the block
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   // word that is expected on the result channel
   typedef struct {
      logic [CNT_W-1:0] count;
      logic             full;
   } match_word_t;

   typedef struct {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] left_index;
      logic [IDX_W-1:0] right_index;
   } req_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_we    = 1'b0;
   logic             csr_index = CSR_LEFT;
   logic [CNT_W-1:0] csr_wdata = '0;

   logic             req_valid = 1'b0;
   logic [CMD_W-1:0] req_command = CMD_CLEAR;
   logic [IDX_W-1:0] req_left = '0;
   logic [IDX_W-1:0] req_right = '0;
   logic             rsp_ready = 1'b0;

   bmm_req_if req_ch ();
   bmm_rsp_if rsp_ch ();

   assign req_ch.valid       = req_valid;
   assign req_ch.command     = req_command;
   assign req_ch.left_index  = req_left;
   assign req_ch.right_index = req_right;
   assign rsp_ch.ready       = rsp_ready;

   bipartite_max_matching DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the block state
   logic [VMAX-1:0]  adj [VMAX];
   logic             partner_ok [VMAX];
   logic [CNT_W-1:0] partner_left [VMAX];
   logic [VMAX-1:0]  seen_right;
   int               fr_left [VMAX+1];
   int               fr_next [VMAX+1];
   int               fr_pick [VMAX+1];
   logic [CNT_W-1:0] left_reg = '0;
   logic [CNT_W-1:0] right_reg = '0;

   req_word_t   pending_words [$];
   match_word_t expected_matches [$];
   int errors = 0;
   int runs_checked = 0;
   int settings_used = 0;
   int words_queued = 0;
   int cycle_count = 0;
   int hold_requests = 0;

   function automatic int sat_count(logic [CNT_W-1:0] r);
      return (r > VMAX) ? VMAX : int'(r);
   endfunction

   // one augmenting-path search from root, explicit frame stack
   function automatic bit augment_from(int root, int rc);
      int depth, u, v, k;
      bit pushed;
      depth = 1;
      fr_left[0] = root; fr_next[0] = 0; fr_pick[0] = 0;
      while (depth > 0) begin
         u = fr_left[depth-1];
         pushed = 0;
         while (fr_next[depth-1] < rc) begin
            v = fr_next[depth-1];
            fr_next[depth-1] = v + 1;
            if (adj[u][v] && !seen_right[v]) begin
               seen_right[v] = 1'b1;
               fr_pick[depth-1] = v;
               if (!partner_ok[v]) begin
                  for (k = depth; k > 0; k--) begin
                     partner_ok[fr_pick[k-1]] = 1'b1;
                     partner_left[fr_pick[k-1]] = fr_left[k-1];
                  end
                  return 1'b1;
               end
               if (depth < VMAX + 1) begin
                  fr_left[depth] = partner_left[v];
                  fr_next[depth] = 0;
                  fr_pick[depth] = 0;
                  depth++;
                  pushed = 1;
                  break;
               end
            end
         end
         if (!pushed) depth--;
      end
      return 1'b0;
   endfunction

   // apply one accepted word to the shadow state
   task automatic predict_word(req_word_t w);
      int lc, rc, u, hits;
      match_word_t m;
      lc = sat_count(left_reg);
      rc = sat_count(right_reg);
      case (w.command)
         CMD_CLEAR: begin
            for (u = 0; u < VMAX; u++) adj[u] = '0;
         end
         CMD_EDGE: begin
            if (w.left_index < lc && w.right_index < rc) adj[w.left_index][w.right_index] = 1'b1;
         end
         CMD_RUN: begin
            hits = 0;
            for (u = 0; u < VMAX; u++) begin
               partner_ok[u] = 1'b0;
               partner_left[u] = '0;
            end
            for (u = 0; u < lc; u++) begin
               seen_right = '0;
               if (augment_from(u, rc)) hits++;
            end
            m.count = hits[CNT_W-1:0];
            m.full = (hits == lc);
            expected_matches.push_back(m);
         end
         default: ;
      endcase
   endtask

   // sender: bursts with random gaps, word taken from the pending queue
   int burst_left = 4;
   int gap_left = 0;
   always @(posedge clock) begin
      req_word_t w;
      logic nv;
      nv = req_valid;
      if (!reset && req_valid && req_ch.ready) begin
         w.command = req_command; w.left_index = req_left; w.right_index = req_right;
         predict_word(w);
         nv = 1'b0;
      end
      if (reset) begin
         nv = 1'b0;
      end else if (!nv) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_command <= w.command;
            req_left    <= w.left_index;
            req_right   <= w.right_index;
            nv = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
      end
      req_valid <= nv;
   end

   // receiver: random stall pattern, clean stretches, and long hold-offs on request
   int mode_left = 0;
   bit noisy = 0;
   int hold_left = 0;
   int holds_seen = 0;
   always @(posedge clock) begin
      if (hold_requests != holds_seen) begin
         holds_seen = hold_requests;
         hold_left = 400;
      end
      if (mode_left == 0) begin
         mode_left = $urandom_range(16, 96);
         noisy = $urandom_range(0, 1);
      end
      mode_left--;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= noisy ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      match_word_t m;
      if (!reset && rsp_ch.valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected result word count=%0d all_matched=%0b", $time,
                     rsp_ch.match_count, rsp_ch.all_matched);
            errors++;
         end else begin
            m = expected_matches.pop_front();
            runs_checked++;
            if (rsp_ch.match_count !== m.count) begin
               $display("%0t: match_count expected %0d actual %0d", $time, m.count,
                        rsp_ch.match_count);
               errors++;
            end
            if (rsp_ch.all_matched !== m.full) begin
               $display("%0t: all_matched expected %0b actual %0b", $time, m.full,
                        rsp_ch.all_matched);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("%0t: timeout", $time);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_word(logic [CMD_W-1:0] c, int l = 0, int r = 0);
      req_word_t w;
      w.command = c; w.left_index = l[IDX_W-1:0]; w.right_index = r[IDX_W-1:0];
      pending_words.push_back(w);
      words_queued++;
   endtask

   // everything sent and answered, then room for a trailing edge write
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_matches.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_counts(int lc, int rc);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_LEFT; csr_wdata <= lc[CNT_W-1:0];
      @(posedge clock);
      csr_index <= CSR_RIGHT; csr_wdata <= rc[CNT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      left_reg = lc[CNT_W-1:0];
      right_reg = rc[CNT_W-1:0];
      settings_used++;
   endtask

   function automatic int pick_index(int eff);
      if (eff == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, VMAX - 1);
      return $urandom_range(0, eff - 1);
   endfunction

   initial begin
      int i, lc, rc, el, er, nseq, nedge, s;
      for (i = 0; i < VMAX; i++) begin
         adj[i] = '0; partner_ok[i] = 1'b0; partner_left[i] = '0;
      end
      seen_right = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty left side after reset
      queue_word(CMD_RUN);
      wait_idle();

      // small graph, out-of-range edges, unused command, a failing search through matched partners
      write_counts(3, 2);
      queue_word(CMD_CLEAR);
      queue_word(CMD_EDGE, 0, 0); queue_word(CMD_EDGE, 1, 0); queue_word(CMD_EDGE, 1, 1);
      queue_word(CMD_EDGE, 2, 1); queue_word(CMD_EDGE, 3, 0); queue_word(CMD_EDGE, 0, 2);
      queue_word(CMD_EDGE, 63, 63); queue_word(CMD_NONE, 63, 63);
      queue_word(CMD_RUN);
      queue_word(CMD_CLEAR); queue_word(CMD_RUN);
      wait_idle();

      // full size and saturated counts
      write_counts(64, 64);
      queue_word(CMD_EDGE, 63, 63); queue_word(CMD_EDGE, 0, 0); queue_word(CMD_EDGE, 42, 21);
      queue_word(CMD_RUN);
      wait_idle();
      write_counts(127, 100);
      queue_word(CMD_EDGE, 63, 0); queue_word(CMD_RUN);
      wait_idle();
      write_counts(1, 0);
      queue_word(CMD_RUN);
      wait_idle();

      // long receiver hold-off while runs keep coming
      write_counts(2, 2);
      queue_word(CMD_CLEAR); queue_word(CMD_EDGE, 0, 1); queue_word(CMD_EDGE, 1, 1);
      hold_requests++;
      for (i = 0; i < 30; i++) queue_word(CMD_RUN);
      wait_idle();

      // random phases: mostly clear/edges/run sequences at small sizes
      while (words_queued < ITEMS) begin
         s = $urandom_range(0, 19);
         if (s == 0) begin lc = 0; rc = $urandom_range(0, 8); end
         else if (s == 1) begin lc = 64; rc = 64; end
         else if (s == 2) begin lc = $urandom_range(65, 127); rc = $urandom_range(65, 127); end
         else begin lc = $urandom_range(1, 10); rc = $urandom_range(1, 10); end
         write_counts(lc, rc);
         el = sat_count(lc[CNT_W-1:0]);
         er = sat_count(rc[CNT_W-1:0]);
         nseq = $urandom_range(1, 4);
         repeat (nseq) begin
            if ($urandom_range(0, 4) != 0) queue_word(CMD_CLEAR);
            nedge = (el >= 32) ? $urandom_range(0, 160) : $urandom_range(0, 2 * el * er + 2);
            repeat (nedge) begin
               if ($urandom_range(0, 29) == 0)
                  queue_word(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
               queue_word(CMD_EDGE, pick_index(el), pick_index(er));
            end
            queue_word(CMD_RUN);
            if ($urandom_range(0, 5) == 0) queue_word(CMD_RUN);
         end
         wait_idle();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d request words over %0d count settings, %0d matching runs checked.",
               words_queued, settings_used, runs_checked);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/bmm_pkg.sv
src/bmm_if.sv
src/bmm_adj_store.sv
src/bmm_ctrl.sv
src/bipartite_max_matching.sv
tb/sv/tb.sv
